// ----- rtl/core/crfe_pkg.sv -----
package crfe_pkg;

    // Screen geometry and the derived address space of the frame store.
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;
    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int X_W    = $clog2(FRAME_WIDTH);
    localparam int Y_W    = $clog2(FRAME_HEIGHT);
    localparam int ADDR_W = $clog2(FRAME_PIXELS);

    // Field widths of the command and result beats.
    localparam int COORD_W = 12;
    localparam int CLIP_W  = COORD_W + 1;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 16;

    // Crosshair cursor: a horizontal and a vertical bar of 2*arm+1 pixels each.
    localparam int CURSOR_ARM   = 3;
    localparam int CURSOR_STEPS = 2 * (2 * CURSOR_ARM + 1);
    localparam int STEP_W       = $clog2(CURSOR_STEPS);

    // Reset values of the configuration registers.
    localparam logic [COLOR_W-1:0] DESKTOP_RESET = 8'd1;
    localparam logic [COLOR_W-1:0] CURSOR_RESET  = 8'd15;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESKTOP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR  = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_PLAN,
        ST_SWEEP,
        ST_CUR_POS,
        ST_CUR_WR,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_RESULT
    } t_state;

    // One write request into the frame store.
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } t_wr_req;

endpackage

// ----- rtl/core/crfe_frame_ram.sv -----
module crfe_frame_ram
    import crfe_pkg::*;
(
    input  logic               i_clk,
    input  t_wr_req            i_wr,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [COLOR_W-1:0] o_rd_data
);

    // Frame store, one palette index per pixel, row-major.
    logic [COLOR_W-1:0] mem [FRAME_PIXELS];
    logic [COLOR_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/clipped_rect_fill_engine_core.sv -----
// Clipped rectangle fill engine over an 8-bit indexed frame store.
// Commands arrive on the slave stream: tuser carries the command code, tdata
// the position, size and fill color. Each command gives exactly one result
// beat on the master stream: the pixel read and the number of pixels written.
// Two configuration registers (desktop color, cursor color) are written over
// a separate valid/ready channel that is always ready; write them only while
// the engine is idle.
// The frame store has one write port, so every fill and clear writes one
// pixel per cycle; that sweep sets the cost of fills and clears. The cursor
// positions each bar pixel and then writes it.
// One command is processed at a time. The result sits in an output register,
// so the next command is accepted while the previous result is still waiting;
// if the receiver stalls for longer, the engine holds its finished result
// and stops accepting until the output register frees up.
// After reset the engine sweeps the whole store to zero, with the command
// channel not ready; configuration writes are taken.
module clipped_rect_fill_engine_core
    import crfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Command channel.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: pos_x[11:0], pos_y[23:12], rect_width[35:24], rect_height[47:36],
    //        fill_color[55:48]
    input  logic [55:0]          i_s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]           i_s_tuser,
    // Result channel.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: read_pixel[7:0], pixels_written[23:8]
    output logic [23:0]          o_m_tdata,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    localparam logic signed [CLIP_W-1:0] FW_S = CLIP_W'(FRAME_WIDTH);
    localparam logic signed [CLIP_W-1:0] FH_S = CLIP_W'(FRAME_HEIGHT);
    localparam logic signed [CLIP_W-1:0] ARM_S = CLIP_W'(CURSOR_ARM);

    t_state n_state;
    t_state r_state;

    // Configuration registers.
    logic [COLOR_W-1:0] r_desktop;
    logic [COLOR_W-1:0] r_cursor;

    // Latched command.
    t_cmd                      r_cmd;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_w;
    logic signed [COORD_W-1:0] r_h;
    logic [COLOR_W-1:0]        r_color;
    logic                      r_init;

    // Sweep and cursor walk.
    logic [X_W-1:0]     r_px;
    logic [Y_W-1:0]     r_py;
    logic [X_W-1:0]     r_x_first;
    logic [X_W-1:0]     r_x_last;
    logic [Y_W-1:0]     r_y_last;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_wrap;
    logic               r_empty;
    logic               r_hit;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_count;
    logic [COLOR_W-1:0] r_rd_pixel;

    // Output register.
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_pixel;
    logic [COUNT_W-1:0] r_out_count;

    // Frame store ports.
    t_wr_req            wr_req;
    logic               rd_en;
    logic [COLOR_W-1:0] rd_data;

    logic s_accept;
    logic out_free;
    logic row_end;
    logic last_pixel;
    logic last_step;

    // Clipping of the latched rectangle (a read is clipped as a 1x1 box).
    logic signed [CLIP_W-1:0] c_x;
    logic signed [CLIP_W-1:0] c_y;
    logic signed [CLIP_W-1:0] c_w;
    logic signed [CLIP_W-1:0] c_h;
    logic signed [CLIP_W-1:0] c_x0;
    logic signed [CLIP_W-1:0] c_y0;
    logic signed [CLIP_W-1:0] c_xe;
    logic signed [CLIP_W-1:0] c_ye;
    logic signed [CLIP_W-1:0] c_xsum;
    logic signed [CLIP_W-1:0] c_ysum;

    // Cursor pixel position.
    logic signed [CLIP_W-1:0] k_off;
    logic signed [CLIP_W-1:0] k_x;
    logic signed [CLIP_W-1:0] k_y;
    logic                     k_hit;

    logic [ADDR_W-1:0] pix_addr;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign row_end    = (r_px == r_x_last);
    assign last_pixel = row_end && (r_py == r_y_last);
    assign last_step  = (r_step == STEP_W'(CURSOR_STEPS - 1));
    assign o_cfg_ready = 1'b1;

    // Row-major address of the current pixel.
    assign pix_addr = ADDR_W'(ADDR_W'(r_py) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(r_px);

    // Clip bounds.
    always_comb begin
        c_x = CLIP_W'(r_x);
        c_y = CLIP_W'(r_y);
        c_w = (r_cmd == CMD_READ) ? CLIP_W'(1) : CLIP_W'(r_w);
        c_h = (r_cmd == CMD_READ) ? CLIP_W'(1) : CLIP_W'(r_h);
        c_xsum = c_x + c_w;
        c_ysum = c_y + c_h;
        c_x0 = (c_x < 0) ? '0 : c_x;
        c_y0 = (c_y < 0) ? '0 : c_y;
        c_xe = (c_xsum > FW_S) ? FW_S : c_xsum;
        c_ye = (c_ysum > FH_S) ? FH_S : c_ysum;
    end

    // Cursor pixel for the current step: even steps walk the horizontal bar,
    // odd steps the vertical bar.
    always_comb begin
        k_off = CLIP_W'(r_step[STEP_W-1:1]) - ARM_S;
        k_x   = CLIP_W'(r_x) + (r_step[0] ? '0 : k_off);
        k_y   = CLIP_W'(r_y) + (r_step[0] ? k_off : '0);
        k_hit = (k_x >= 0) && (k_x < FW_S) && (k_y >= 0) && (k_y < FH_S);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (t_cmd'(i_s_tuser))
                        CMD_CLEAR:  n_state = ST_SWEEP;
                        CMD_CURSOR: n_state = ST_CUR_POS;
                        default:    n_state = ST_CLIP;
                    endcase
                end
            end
            ST_CLIP:     n_state = ST_PLAN;
            ST_PLAN: begin
                if (r_empty) begin
                    n_state = ST_RESULT;
                end else if (r_cmd == CMD_READ) begin
                    n_state = ST_RD_ISSUE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (last_pixel) begin
                    n_state = r_init ? ST_IDLE : ST_RESULT;
                end
            end
            ST_CUR_POS:  n_state = ST_CUR_WR;
            ST_CUR_WR:   n_state = last_step ? ST_RESULT : ST_CUR_POS;
            ST_RD_ISSUE: n_state = ST_RD_DATA;
            ST_RD_DATA:  n_state = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Handshake and frame store controls.
    always_comb begin
        o_s_tready  = 1'b0;
        wr_req.en   = 1'b0;
        wr_req.addr = r_addr;
        wr_req.data = r_color;
        rd_en       = 1'b0;
        case (r_state)
            ST_IDLE:     o_s_tready = 1'b1;
            ST_SWEEP:    wr_req.en = 1'b1;
            ST_CUR_WR: begin
                wr_req.en   = r_hit;
                wr_req.addr = pix_addr;
            end
            ST_RD_ISSUE: rd_en = 1'b1;
            default:     ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desktop <= DESKTOP_RESET;
            r_cursor  <= CURSOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DESKTOP: r_desktop <= i_cfg_data;
                CFG_CURSOR:  r_cursor  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Command datapath: latch, clip, sweep, cursor walk and read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset runs a full-screen sweep that writes zero.
            r_init    <= 1'b1;
            r_color   <= '0;
            r_px      <= '0;
            r_py      <= '0;
            r_x_first <= '0;
            r_x_last  <= X_W'(FRAME_WIDTH - 1);
            r_y_last  <= Y_W'(FRAME_HEIGHT - 1);
            r_addr    <= '0;
            r_wrap    <= ADDR_W'(1);
            r_count   <= '0;
            r_step    <= '0;
            r_empty   <= 1'b0;
            r_hit     <= 1'b0;
            r_rd_pixel <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_cmd      <= t_cmd'(i_s_tuser);
                        r_x        <= i_s_tdata[11:0];
                        r_y        <= i_s_tdata[23:12];
                        r_w        <= i_s_tdata[35:24];
                        r_h        <= i_s_tdata[47:36];
                        r_init     <= 1'b0;
                        r_count    <= '0;
                        r_step     <= '0;
                        r_rd_pixel <= '0;
                        // A clear is a fill of the whole screen.
                        r_px       <= '0;
                        r_py       <= '0;
                        r_x_first  <= '0;
                        r_x_last   <= X_W'(FRAME_WIDTH - 1);
                        r_y_last   <= Y_W'(FRAME_HEIGHT - 1);
                        r_addr     <= '0;
                        r_wrap     <= ADDR_W'(1);
                        case (t_cmd'(i_s_tuser))
                            CMD_CLEAR:  r_color <= r_desktop;
                            CMD_CURSOR: r_color <= r_cursor;
                            default:    r_color <= i_s_tdata[55:48];
                        endcase
                    end
                end
                ST_CLIP: begin
                    r_empty   <= (c_x0 >= c_xe) || (c_y0 >= c_ye);
                    r_px      <= X_W'(c_x0);
                    r_py      <= Y_W'(c_y0);
                    r_x_first <= X_W'(c_x0);
                    r_x_last  <= X_W'(c_xe - CLIP_W'(1));
                    r_y_last  <= Y_W'(c_ye - CLIP_W'(1));
                end
                ST_PLAN: begin
                    r_addr <= pix_addr;
                    r_wrap <= ADDR_W'(FRAME_WIDTH) - ADDR_W'(r_x_last - r_x_first);
                end
                ST_SWEEP: begin
                    if (r_count != '1) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                    if (row_end) begin
                        r_px   <= r_x_first;
                        r_py   <= r_py + Y_W'(1);
                        r_addr <= r_addr + r_wrap;
                    end else begin
                        r_px   <= r_px + X_W'(1);
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                ST_CUR_POS: begin
                    r_px  <= X_W'(k_x);
                    r_py  <= Y_W'(k_y);
                    r_hit <= k_hit;
                end
                ST_CUR_WR: begin
                    if (r_hit) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                    r_step <= r_step + STEP_W'(1);
                end
                ST_RD_DATA: r_rd_pixel <= rd_data;
                default:    ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_pixel <= '0;
            r_out_count <= '0;
        end else if (r_state == ST_RESULT && out_free) begin
            r_out_valid <= 1'b1;
            r_out_pixel <= r_rd_pixel;
            r_out_count <= r_count;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_count, r_out_pixel};

    crfe_frame_ram u_frame_ram (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // Every store write lands inside the frame.
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (wr_req.addr < ADDR_W'(FRAME_PIXELS)))
        else $error("frame store write outside the frame");

    // The sweep never walks past its clipped bounds.
    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_px <= r_x_last) && (r_py <= r_y_last)
            && (r_px >= r_x_first))
        else $error("sweep outside clipped rectangle");

    // A cursor writes at most one pixel per step.
    a_cursor_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CUR_WR) |-> (r_count <= COUNT_W'(r_step)))
        else $error("cursor pixel count exceeds steps taken");

    // A nonzero pixel is only reported by a read, which writes nothing.
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pixel != '0)) |-> (r_out_count == '0))
        else $error("read result with nonzero write count");
`endif

endmodule

// ----- tb/clipped_rect_fill_engine_core_test.sv -----
module clipped_rect_fill_engine_core_test;
    import crfe_pkg::*;

    // The hang guard allows for the power-on sweep plus every command taking a
    // full-screen sweep with the longest stalls, several times over.
    localparam int CYCLE_LIMIT = 40_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int COUNT_MAX = 65535;

    // Expected contents of one result beat.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic [COUNT_W-1:0] count;
    } t_draw_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [55:0]          i_s_tdata = '0;
    logic [1:0]           i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [23:0]          o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0]   i_cfg_data = '0;

    // Shadow copy of the frame store and color registers.
    logic [COLOR_W-1:0] frame_shadow [FRAME_PIXELS];
    logic [COLOR_W-1:0] desktop_shadow = DESKTOP_RESET;
    logic [COLOR_W-1:0] cursor_shadow = CURSOR_RESET;

    t_draw_result pending_draw_results [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int random_clears = 0;

    clipped_rect_fill_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Writes one cursor pixel into the shadow store when it lies on screen.
    function automatic int plot_cursor_pixel(input int px, input int py);
        if (px < 0 || px >= FRAME_WIDTH || py < 0 || py >= FRAME_HEIGHT) begin
            return 0;
        end
        frame_shadow[py * FRAME_WIDTH + px] = cursor_shadow;
        return 1;
    endfunction

    // Applies one command to the shadow store and returns the beat it should
    // produce: the pixel read and the number of pixels painted.
    function automatic t_draw_result paint_command(
        input t_cmd               cmd,
        input logic signed [11:0] x,
        input logic signed [11:0] y,
        input logic signed [11:0] w,
        input logic signed [11:0] h,
        input logic [7:0]         color
    );
        t_draw_result res;
        int x0;
        int y0;
        int x1;
        int y1;
        int r;
        int c;
        int n;
        res.pixel = '0;
        n = 0;
        x0 = x;
        y0 = y;
        x1 = x0 + int'(w);
        y1 = y0 + int'(h);
        case (cmd)
            CMD_CLEAR: begin
                for (r = 0; r < FRAME_PIXELS; r++) begin
                    frame_shadow[r] = desktop_shadow;
                end
                n = FRAME_PIXELS;
            end
            CMD_FILL: begin
                // Clip once to the screen; an empty span in either axis paints nothing.
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > FRAME_WIDTH) x1 = FRAME_WIDTH;
                if (y1 > FRAME_HEIGHT) y1 = FRAME_HEIGHT;
                if (x0 < x1 && y0 < y1) begin
                    for (r = y0; r < y1; r++) begin
                        for (c = x0; c < x1; c++) begin
                            frame_shadow[r * FRAME_WIDTH + c] = color;
                            n++;
                        end
                    end
                end
            end
            CMD_CURSOR: begin
                // The center is painted by both bars and so counts twice.
                for (c = -CURSOR_ARM; c <= CURSOR_ARM; c++) begin
                    n += plot_cursor_pixel(x0 + c, y0);
                    n += plot_cursor_pixel(x0, y0 + c);
                end
            end
            default: begin
                if (x0 >= 0 && x0 < FRAME_WIDTH && y0 >= 0 && y0 < FRAME_HEIGHT) begin
                    res.pixel = frame_shadow[y0 * FRAME_WIDTH + x0];
                end
            end
        endcase
        if (n > COUNT_MAX) n = COUNT_MAX;
        res.count = COUNT_W'(n);
        return res;
    endfunction

    // Result side: random back-pressure and a check of every accepted beat.
    always @(posedge i_clk) begin : result_check
        t_draw_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_draw_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", int'(o_m_tdata), 0);
            end else begin
                want = pending_draw_results.pop_front();
                if (o_m_tdata[7:0] !== want.pixel) begin
                    report_mismatch("read_pixel", int'(o_m_tdata[7:0]), int'(want.pixel));
                end
                if (o_m_tdata[23:8] !== want.count) begin
                    report_mismatch("pixels_written", int'(o_m_tdata[23:8]),
                                    int'(want.count));
                end
            end
        end
        i_m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    // Presents one command beat and records its expected result once taken.
    // tvalid stays high afterwards so back-to-back beats need no re-raise.
    task automatic send_command(
        input t_cmd       cmd,
        input int         x,
        input int         y,
        input int         w,
        input int         h,
        input logic [7:0] color
    );
        logic signed [11:0] bx;
        logic signed [11:0] by;
        logic signed [11:0] bw;
        logic signed [11:0] bh;
        bx = 12'(x);
        by = 12'(y);
        bw = 12'(w);
        bh = 12'(h);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {color, bh, bw, by, bx};
        do @(posedge i_clk); while (!o_s_tready);
        pending_draw_results.push_back(paint_command(cmd, bx, by, bw, bh, color));
    endtask

    task automatic stop_commands();
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_draw_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both color registers; only called with the engine idle.
    task automatic write_colors(input logic [7:0] desktop, input logic [7:0] cursor);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DESKTOP;
        i_cfg_data <= desktop;
        do @(posedge i_clk); while (!o_cfg_ready);
        desktop_shadow = desktop;
        i_cfg_index <= CFG_CURSOR;
        i_cfg_data <= cursor;
        do @(posedge i_clk); while (!o_cfg_ready);
        cursor_shadow = cursor;
        i_cfg_valid <= 1'b0;
    endtask

    // Store is zero after the power-on sweep; clear uses the reset desktop color.
    task automatic test_power_on_state();
        send_command(CMD_READ, 0, 0, 0, 0, 8'h00);
        send_command(CMD_CLEAR, 0, 0, 0, 0, 8'h00);
        send_command(CMD_READ, 160, 100, 0, 0, 8'h00);
        stop_commands();
        wait_results_drained();
    endtask

    // Full-screen, empty, off-screen and partly visible fills.
    task automatic test_fill_clipping();
        send_command(CMD_FILL, -5, -5, 2047, 2047, 8'hFF);
        send_command(CMD_FILL, 10, 10, 0, 5, 8'h11);
        send_command(CMD_FILL, 10, 10, 5, -2048, 8'h22);
        send_command(CMD_FILL, 320, 0, 10, 10, 8'h33);
        send_command(CMD_FILL, -10, 0, 10, 10, 8'h44);
        send_command(CMD_FILL, 315, 195, 10, 10, 8'h00);
        send_command(CMD_FILL, 2047, 2047, 2047, 2047, 8'h55);
        send_command(CMD_FILL, -2048, -2048, 2047, 2047, 8'h66);
        send_command(CMD_READ, 314, 194, 0, 0, 8'h00);
        send_command(CMD_READ, 319, 199, 0, 0, 8'h00);
        stop_commands();
        wait_results_drained();
    endtask

    // Fully visible cursor, corners, a single visible pixel and none at all.
    task automatic test_cursor_clipping();
        send_command(CMD_CURSOR, 10, 10, 0, 0, 8'h00);
        send_command(CMD_READ, 10, 10, 0, 0, 8'h00);
        send_command(CMD_READ, 14, 10, 0, 0, 8'h00);
        send_command(CMD_CURSOR, 0, 0, 0, 0, 8'h00);
        send_command(CMD_CURSOR, 319, 199, 0, 0, 8'h00);
        send_command(CMD_CURSOR, -3, 5, 0, 0, 8'h00);
        send_command(CMD_CURSOR, -2048, 2047, 0, 0, 8'h00);
        stop_commands();
        wait_results_drained();
    endtask

    // Reads just outside the left, right and bottom edges and one far off screen return zero.
    task automatic test_offscreen_reads();
        send_command(CMD_READ, -1, 0, 0, 0, 8'h00);
        send_command(CMD_READ, 320, 0, 0, 0, 8'h00);
        send_command(CMD_READ, 0, 200, 0, 0, 8'h00);
        send_command(CMD_READ, 2047, -2048, 0, 0, 8'h00);
        stop_commands();
        wait_results_drained();
    endtask

    // Extreme register values reach the clear and the cursor.
    task automatic test_color_registers();
        write_colors(8'hFF, 8'h00);
        send_command(CMD_CLEAR, 0, 0, 0, 0, 8'h00);
        send_command(CMD_CURSOR, 100, 50, 0, 0, 8'h00);
        send_command(CMD_READ, 100, 50, 0, 0, 8'h00);
        send_command(CMD_READ, 0, 0, 0, 0, 8'h00);
        stop_commands();
        wait_results_drained();
    endtask

    // One random command: mostly near-screen positions and small sizes, with
    // some full-range fields and only a couple of full clears.
    task automatic send_random_command();
        int pick;
        int mode;
        t_cmd cmd;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [11:0] w;
        logic signed [11:0] h;
        pick = $urandom_range(99);
        if (pick < 2 && random_clears < 2) begin
            cmd = CMD_CLEAR;
            random_clears++;
        end else if (pick < 47) begin
            cmd = CMD_FILL;
        end else if (pick < 70) begin
            cmd = CMD_CURSOR;
        end else begin
            cmd = CMD_READ;
        end
        if ($urandom_range(99) < 70) begin
            x = 12'(int'($urandom_range(339)) - 20);
            y = 12'(int'($urandom_range(219)) - 20);
        end else begin
            x = 12'($urandom);
            y = 12'($urandom);
        end
        w = 12'(int'($urandom_range(34)) - 4);
        h = 12'(int'($urandom_range(34)) - 4);
        mode = $urandom_range(99);
        if (mode >= 95) begin
            w = 12'($urandom);
            h = 12'($urandom);
        end else if (mode >= 80) begin
            if ($urandom_range(1) == 1) w = 12'($urandom);
            else h = 12'($urandom);
        end
        send_command(cmd, x, y, w, h, 8'($urandom));
    endtask

    // A phase of random traffic under one idling pattern and color setting.
    task automatic test_random_traffic(input int items, input int s_pct, input int r_pct,
                                       input bit hold_midway);
        int i;
        write_colors(8'($urandom), 8'($urandom));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (i = 0; i < items; i++) begin
            send_random_command();
            // Hold off until the engine has handed back everything.
            if (hold_midway && i == items / 2) begin
                stop_commands();
                wait_results_drained();
            end
        end
        stop_commands();
        wait_results_drained();
    endtask

    initial begin
        foreach (frame_shadow[i]) frame_shadow[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_state();
        test_fill_clipping();
        test_cursor_clipping();
        test_offscreen_reads();
        test_color_registers();

        // Writes the opposite register extremes before phase one, which then sets random colors.
        send_idle_pct = 15;
        recv_idle_pct = 51;
        write_colors(8'h00, 8'hFF);
        test_random_traffic(24, 15, 51, 1'b0);
        test_random_traffic(24, 51, 15, 1'b0);
        test_random_traffic(24, 0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
